// File: hdl/bfam_pkg.sv
// Shared types, codes and constants for the Bellman-Ford adjacency matrix block.
package bfam_pkg;

  localparam int MAX_VERTICES_DEFAULT = 16;
  localparam int VERTEX_LIMIT = 16;

  localparam int VIDX_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 24;
  localparam int UNREACH_W = 23;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNREACHED_VALUE = 2'd2;

  localparam logic [COUNT_W-1:0]   VERTEX_COUNT_RESET    = 5'd16;
  localparam logic [VIDX_W-1:0]    SOURCE_VERTEX_RESET   = 4'd0;
  localparam logic [UNREACH_W-1:0] UNREACHED_VALUE_RESET = 23'd200;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_START,
    ST_ROW_START,
    ST_EDGE_RD,
    ST_EDGE_ADD,
    ST_EDGE_UPD,
    ST_OUT_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic write;
    logic init;
    logic pass_start;
    logic next_pass;
    logic enter_check;
    logic row_load;
    logic edge_read;
    logic edge_add;
    logic edge_update;
    logic out_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic row_over;
    logic pass_last;
    logic checking;
    logic col_last;
    logic n_zero;
    logic out_free;
  } status_t;

endpackage

// File: hdl/bellman_ford_adjacency_matrix.sv
// Top level of the Bellman-Ford shortest path block over a stored adjacency matrix.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------------
//  input    | in_valid / in_ready  | opcode, edge_from, edge_to, edge_weight
//  result   | out_valid/ out_ready | vertex_index, distance, predecessor, has_predecessor,
//           |                      | no_negative_cycle, last
//  config   | cfg_write            | cfg_index, cfg_data
//
// Clear and edge-write items are accepted one per cycle while no run is in progress.
// A run item steps each edge through the read, add and update states of the shared
// read/add/compare unit, with a row-start state per row and a pass-start state per pass
// (n-1 relaxation passes and one check pass), and then emits n results.
// Clear resets the valid bits of the entries within the current vertex count at once; reset needs no clearing pass.
// Input is held off during a run; a stalled result holds emission until the result
// register is free.
module bellman_ford_adjacency_matrix
  import bfam_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 opcode,
  input  logic [VIDX_W-1:0]          edge_from,
  input  logic [VIDX_W-1:0]          edge_to,
  input  logic signed [WEIGHT_W-1:0] edge_weight,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [VIDX_W-1:0]          vertex_index,
  output logic signed [DIST_W-1:0]   distance,
  output logic [VIDX_W-1:0]          predecessor,
  output logic                       has_predecessor,
  output logic                       no_negative_cycle,
  output logic                       last,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  cmd_t    cmd;
  status_t sts;

  bfam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfam_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .edge_from         (edge_from),
    .edge_to           (edge_to),
    .edge_weight       (edge_weight),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .vertex_index      (vertex_index),
    .distance          (distance),
    .predecessor       (predecessor),
    .has_predecessor   (has_predecessor),
    .no_negative_cycle (no_negative_cycle),
    .last              (last)
  );

endmodule

// File: hdl/bfam_ctrl.sv
// Controller state machine sequencing passes, rows, edges and result emission.
module bfam_ctrl
  import bfam_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  output logic       in_ready,
  input  status_t    sts,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (opcode)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_WRITE: cmd.write = 1'b1;
            OP_RUN: begin
              cmd.init   = 1'b1;
              state_next = ST_PASS_START;
            end
            default: ;
          endcase
        end
      end
      ST_PASS_START: begin
        cmd.pass_start = 1'b1;
        state_next     = ST_ROW_START;
      end
      ST_ROW_START: begin
        priority if (sts.row_over && sts.checking && sts.n_zero) begin
          state_next = ST_IDLE;
        end else if (sts.row_over && sts.checking) begin
          cmd.out_start = 1'b1;
          state_next    = ST_OUT_EMIT;
        end else if (sts.row_over && sts.pass_last) begin
          cmd.enter_check = 1'b1;
          state_next      = ST_PASS_START;
        end else if (sts.row_over) begin
          cmd.next_pass = 1'b1;
          state_next    = ST_PASS_START;
        end else begin
          cmd.row_load = 1'b1;
          state_next   = ST_EDGE_RD;
        end
      end
      ST_EDGE_RD: begin
        cmd.edge_read = 1'b1;
        state_next    = ST_EDGE_ADD;
      end
      ST_EDGE_ADD: begin
        cmd.edge_add = 1'b1;
        state_next   = ST_EDGE_UPD;
      end
      ST_EDGE_UPD: begin
        cmd.edge_update = 1'b1;
        state_next      = sts.col_last ? ST_ROW_START : ST_EDGE_RD;
      end
      ST_OUT_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.col_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/bfam_dp.sv
// Datapath: edge store, estimates, counters, relaxation arithmetic and result register.
module bfam_dp
  import bfam_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output status_t                      sts,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic [VIDX_W-1:0]            edge_from,
  input  logic [VIDX_W-1:0]            edge_to,
  input  logic signed [WEIGHT_W-1:0]   edge_weight,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [VIDX_W-1:0]            vertex_index,
  output logic signed [DIST_W-1:0]     distance,
  output logic [VIDX_W-1:0]            predecessor,
  output logic                         has_predecessor,
  output logic                         no_negative_cycle,
  output logic                         last
);

  localparam int NV    = (MAX_VERTICES < VERTEX_LIMIT) ? MAX_VERTICES : VERTEX_LIMIT;
  localparam int VW    = $clog2(NV);
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam logic [COUNT_W-1:0] NV_COUNT = COUNT_W'(NV);
  localparam logic [6:0] MAXV = 7'(MAX_VERTICES);
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  logic [COUNT_W-1:0]   vertex_count;
  logic [VIDX_W-1:0]    source_vertex;
  logic [UNREACH_W-1:0] unreached_value;

  logic signed [WEIGHT_W-1:0] edge_mem [DEPTH];
  logic [DEPTH-1:0]           edge_valid;

  logic signed [DIST_W-1:0] dist_est [NV];
  logic [VIDX_W-1:0]        pred [NV];
  logic [NV-1:0]            pred_valid;

  logic [COUNT_W-1:0]       row;
  logic [VIDX_W-1:0]        col;
  logic [VIDX_W-1:0]        pass;
  logic                     checking;
  logic                     clean;
  logic signed [DIST_W-1:0] row_dist;
  logic signed [WEIGHT_W-1:0] rd_w;
  logic                     rd_v;
  logic signed [DIST_W-1:0] cand;
  logic                     w_nz;

  logic [COUNT_W-1:0]       n_eff;
  logic                     wr_ok;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic [VW-1:0]            rd_idx;
  logic signed [DIST_W-1:0] dist_rd;
  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] sum_sat;
  logic                     better;
  logic                     src_in;

  assign n_eff   = (vertex_count > NV_COUNT) ? NV_COUNT : vertex_count;
  assign wr_ok   = ({3'd0, edge_from} < MAXV) && ({3'd0, edge_to} < MAXV);
  assign wr_addr = {edge_from[VW-1:0], edge_to[VW-1:0]};
  assign rd_addr = {row[VW-1:0], col[VW-1:0]};
  assign rd_idx  = cmd.row_load ? row[VW-1:0] : col[VW-1:0];
  assign dist_rd = dist_est[rd_idx];
  assign src_in  = {1'b0, source_vertex} < n_eff;

  assign sum = {row_dist[DIST_W-1], row_dist}
             + {{(DIST_W+1-WEIGHT_W){rd_w[WEIGHT_W-1]}}, rd_w};
  assign sum_sat = (sum[DIST_W] != sum[DIST_W-1]) ?
                   (sum[DIST_W] ? DIST_MIN : DIST_MAX) : sum[DIST_W-1:0];
  assign better  = w_nz && (dist_rd > cand);

  assign sts.row_over  = row >= n_eff;
  assign sts.pass_last = ({1'b0, pass} + 5'd2) >= n_eff;
  assign sts.checking  = checking;
  assign sts.col_last  = ({1'b0, col} + 5'd1) == n_eff;
  assign sts.n_zero    = n_eff == '0;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count    <= VERTEX_COUNT_RESET;
      source_vertex   <= SOURCE_VERTEX_RESET;
      unreached_value <= UNREACHED_VALUE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT:    vertex_count    <= cfg_data[COUNT_W-1:0];
        CFG_SOURCE_VERTEX:   source_vertex   <= cfg_data[VIDX_W-1:0];
        CFG_UNREACHED_VALUE: unreached_value <= cfg_data[UNREACH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_valid <= '0;
    end else if (cmd.clear) begin
      for (int a = 0; a < DEPTH; a++) begin
        if ((COUNT_W'(AW'(a) >> VW) < n_eff) && (COUNT_W'(a % (1 << VW)) < n_eff)) begin
          edge_valid[a] <= 1'b0;
        end
      end
    end else if (cmd.write && wr_ok) begin
      edge_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      edge_mem[wr_addr] <= edge_weight;
    end
    if (cmd.edge_read) begin
      rd_w <= edge_mem[rd_addr];
      rd_v <= edge_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_add) begin
      cand <= sum_sat;
      w_nz <= rd_v && (rd_w != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      pass     <= '0;
      checking <= 1'b0;
      clean    <= 1'b1;
    end else begin
      if (cmd.init) begin
        pass     <= '0;
        checking <= n_eff < 5'd2;
        clean    <= 1'b1;
      end
      if (cmd.next_pass) begin
        pass <= pass + 4'd1;
      end
      if (cmd.enter_check) begin
        checking <= 1'b1;
      end
      if (cmd.pass_start) begin
        row <= (!checking && pass == '0) ? {1'b0, source_vertex} : '0;
      end
      if (cmd.row_load || cmd.out_start) begin
        col <= '0;
      end
      if (cmd.edge_update) begin
        if (checking && better) begin
          clean <= 1'b0;
        end
        if (sts.col_last) begin
          row <= row + 5'd1;
        end else begin
          col <= col + 4'd1;
        end
      end
      if (cmd.emit) begin
        col <= col + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      row_dist <= dist_rd;
    end else if (cmd.edge_update && !checking && better && ({1'b0, col} == row)) begin
      row_dist <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_valid <= '0;
    end else if (cmd.init) begin
      pred_valid <= '0;
    end else if (cmd.edge_update && !checking && better) begin
      pred_valid[col[VW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int k = 0; k < NV; k++) begin
        dist_est[k] <= (src_in && (source_vertex == VIDX_W'(k))) ? '0
                                                                  : DIST_W'(unreached_value);
      end
    end else if (cmd.edge_update && !checking && better) begin
      dist_est[col[VW-1:0]] <= cand;
      pred[col[VW-1:0]]     <= row[VIDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      vertex_index      <= col;
      distance          <= dist_rd;
      predecessor       <= pred_valid[col[VW-1:0]] ? pred[col[VW-1:0]] : '0;
      has_predecessor   <= pred_valid[col[VW-1:0]];
      no_negative_cycle <= clean;
      last              <= sts.col_last;
    end
  end

endmodule
